### rtl/sbag_pkg.sv
`default_nettype none

package sbag_pkg;

  // Field widths fixed by the register map and the stream payloads
  localparam int BLK_W     = 24;  // total_blocks, block_stride
  localparam int ITER_W    = 32;  // iteration count, per-entry counters
  localparam int ENTRY_W   = 64;  // distance table entry
  localparam int DCOUNT_W  = 3;
  localparam int CFG_IDX_W = 4;
  localparam int NUM_ENTRY_REGS = 4;

  // Defaults for the top-level parameters
  localparam int MAX_DISTANCES_DEF    = 4;
  localparam int BLOCK_INDEX_BITS_DEF = 24;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DCOUNT = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_WMODE  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY0 = CFG_IDX_W'(4);

  // Input command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_NEXT  = 1'b1;

  // Position within one iteration
  typedef enum logic [2:0] {
    PH_HEAD = 3'b001,  // iteration head touch of block 0
    PH_DIST = 3'b010,  // distance head touch of block 0
    PH_TRAV = 3'b100   // traversal access
  } phase_t;

  // Request to the remainder unit
  typedef struct packed {
    logic             start;
    logic [BLK_W-1:0] num_a;
    logic [BLK_W-1:0] num_b;
    logic [BLK_W-1:0] divisor;
  } rem_req_t;

  // Status and results of the remainder unit
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [BLK_W-1:0] rem_a;
    logic [BLK_W-1:0] rem_b;
  } rem_res_t;

  // A buffer size of zero counts as one block
  function automatic logic [BLK_W-1:0] eff_total(input logic [BLK_W-1:0] t);
    eff_total = (t == '0) ? BLK_W'(1) : t;
  endfunction

endpackage

`default_nettype wire

### rtl/sbag_remainder.sv
`default_nettype none

// Two restoring remainders against a shared divisor, one bit per cycle.
module sbag_remainder (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sbag_pkg::rem_req_t req,
  output sbag_pkg::rem_res_t      res
);

  localparam int W   = sbag_pkg::BLK_W;
  localparam int CNT_W = $clog2(W + 1);

  logic             busy_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [W-1:0]     na_r, nb_r, ra_r, rb_r, t_r;

  logic [W:0]       ra_sh, rb_sh, ra_new, rb_new;

  // One restoring step for each operand
  always_comb begin
    ra_sh  = {ra_r, na_r[W-1]};
    rb_sh  = {rb_r, nb_r[W-1]};
    ra_new = (ra_sh >= {1'b0, t_r}) ? ra_sh - {1'b0, t_r} : ra_sh;
    rb_new = (rb_sh >= {1'b0, t_r}) ? rb_sh - {1'b0, t_r} : rb_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(W);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      na_r <= req.num_a;
      nb_r <= req.num_b;
      t_r  <= req.divisor;
      ra_r <= '0;
      rb_r <= '0;
    end else if (busy_r) begin
      na_r <= na_r << 1;
      nb_r <= nb_r << 1;
      ra_r <= ra_new[W-1:0];
      rb_r <= rb_new[W-1:0];
    end
  end

  assign res.busy  = busy_r | done_r;
  assign res.done  = done_r;
  assign res.rem_a = ra_r;
  assign res.rem_b = rb_r;

endmodule

`default_nettype wire

### rtl/strided_block_access_generator.sv
// Strided block access generator: emits the block access sequence of a
// reuse-distance memory benchmark, one access per "next" request in an active run.
// Channels:
//   in_*  : requests. tuser[0] is the command (0 start, 1 next);
//           tdata carries the iteration count for a start.
//   out_* : accesses. tdata is the block index, tuser[0] marks a
//           read-modify-write access, tlast marks the final access of a run.
//   cfg_* : register writes (index, 64-bit data), always ready.
// An access appears on out_* in the cycle after its next request is
// taken. Requests are taken one per cycle while no reduction runs and
// the output is not stalled; all of the step work sits between the
// state registers and the output register. A write to total_blocks or
// block_stride starts a bit-serial remainder unit that reduces the
// stride and the current block; in_tready stays low until its results land.
// Reset leaves the run idle and the registers at their reset values; no
// reduction pass is needed after reset.
// When the receiver stalls, the output register holds its access and
// in_tready drops until it is taken.
`default_nettype none

module strided_block_access_generator #(
  parameter int MAX_DISTANCES    = sbag_pkg::MAX_DISTANCES_DEF,
  parameter int BLOCK_INDEX_BITS = sbag_pkg::BLOCK_INDEX_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // request stream
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [sbag_pkg::ITER_W-1:0]   in_tdata,   // [31:0] iterations
  input  wire logic [0:0]                    in_tuser,   // [0] command
  // access stream
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [((BLOCK_INDEX_BITS+7)/8)*8-1:0] out_tdata, // block_index, zero pad
  output logic [0:0]                         out_tuser,  // [0] read_modify_write
  output logic                               out_tlast,  // run_done
  // configuration writes
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [sbag_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sbag_pkg::ENTRY_W-1:0]  cfg_data
);

  localparam int BW    = sbag_pkg::BLK_W;
  localparam int IW    = sbag_pkg::ITER_W;
  localparam int BIB   = BLOCK_INDEX_BITS;
  localparam int OUT_W = ((BLOCK_INDEX_BITS + 7) / 8) * 8;
  localparam int DI_W  = (MAX_DISTANCES > 1) ? $clog2(MAX_DISTANCES) : 1;
  localparam logic [3:0] MAXD = 4'(MAX_DISTANCES);

  // Configuration registers
  logic [BW-1:0]                    total_r, stride_r, stridem_r;
  logic [sbag_pkg::DCOUNT_W-1:0]    dcount_r;
  logic                             wmode_r;
  logic [sbag_pkg::ENTRY_W-1:0]     entry_r [MAX_DISTANCES];

  // Run state
  logic                 run_active_r, run_active_nxt;
  sbag_pkg::phase_t     phase_r, phase_nxt;
  logic [IW-1:0]        iter_left_r, iter_left_nxt;
  logic [DI_W-1:0]      dist_idx_r, dist_idx_nxt;
  logic [IW-1:0]        trav_cnt_r, trav_cnt_nxt;
  logic [IW-1:0]        blk_cnt_r, blk_cnt_nxt;
  logic [BIB-1:0]       cur_r, cur_nxt;      // block as stored
  logic [BW-1:0]        curm_r, curm_nxt;    // stored block modulo buffer size

  // Output register
  logic                 out_valid_r;
  logic [BIB-1:0]       out_blk_r;
  logic                 out_rmw_r, out_last_r;

  // Step signals
  logic                 cfg_we, in_acc;
  logic [BW-1:0]        eff_t;
  logic [3:0]           ecount;
  logic [BW:0]          sum_w, step_mod;
  logic [BIB-1:0]       step_cur;
  logic [BW-1:0]        step_curm;
  logic [IW:0]          blk_plus;
  logic [IW-1:0]        blocks_sel, travs_sel;
  logic                 do_check, do_enter;
  logic [DI_W:0]        enter_d;
  logic                 res_valid, res_rmw, res_done;
  logic [BIB-1:0]       res_blk;

  sbag_pkg::rem_req_t   rem_req;
  sbag_pkg::rem_res_t   rem_res;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;
  assign in_tready = ~rem_res.busy & (~out_valid_r | out_tready);
  assign in_acc    = in_tvalid & in_tready;

  // Reduce stride and current block whenever the size or the stride is written
  always_comb begin
    rem_req.start   = cfg_we & ((cfg_index == sbag_pkg::REG_TOTAL) |
                                (cfg_index == sbag_pkg::REG_STRIDE));
    rem_req.num_a   = BW'(cur_r);
    rem_req.num_b   = (cfg_index == sbag_pkg::REG_STRIDE) ? cfg_data[BW-1:0] : stride_r;
    rem_req.divisor = sbag_pkg::eff_total((cfg_index == sbag_pkg::REG_TOTAL) ?
                                          cfg_data[BW-1:0] : total_r);
  end

  sbag_remainder u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .res   (rem_res)
  );

  // Effective size, distance count and the stride step
  always_comb begin
    eff_t     = sbag_pkg::eff_total(total_r);
    ecount    = (4'(dcount_r) > MAXD) ? MAXD : 4'(dcount_r);
    sum_w     = {1'b0, curm_r} + {1'b0, stridem_r};
    step_mod  = (sum_w >= {1'b0, eff_t}) ? sum_w - {1'b0, eff_t} : sum_w;
    step_cur  = BIB'(step_mod[BW-1:0]);
    step_curm = BW'(step_cur);
    blk_plus  = {1'b0, blk_cnt_r} + (IW+1)'(1);
    blocks_sel = entry_r[dist_idx_r][IW-1:0];
    travs_sel  = entry_r[dist_idx_r][2*IW-1:IW];
  end

  // One request: a start loads the run; a next issues the access and advances the run
  always_comb begin
    run_active_nxt = run_active_r;
    phase_nxt      = phase_r;
    iter_left_nxt  = iter_left_r;
    dist_idx_nxt   = dist_idx_r;
    trav_cnt_nxt   = trav_cnt_r;
    blk_cnt_nxt    = blk_cnt_r;
    cur_nxt        = cur_r;
    curm_nxt       = curm_r;
    res_valid      = 1'b0;
    res_blk        = '0;
    res_rmw        = 1'b0;
    res_done       = 1'b0;
    do_check       = 1'b0;
    do_enter       = 1'b0;
    enter_d        = '0;

    if (in_acc) begin
      if (in_tuser[0] == sbag_pkg::CMD_START) begin
        iter_left_nxt  = in_tdata;
        run_active_nxt = (in_tdata != '0);
        phase_nxt      = sbag_pkg::PH_HEAD;
        dist_idx_nxt   = '0;
        trav_cnt_nxt   = '0;
        blk_cnt_nxt    = '0;
        cur_nxt        = '0;
        curm_nxt       = '0;
      end else if (run_active_r) begin
        res_valid = 1'b1;
        if (phase_r == sbag_pkg::PH_TRAV) begin
          res_blk = cur_r;
          res_rmw = wmode_r;
        end

        unique case (phase_r)
          sbag_pkg::PH_HEAD: begin
            do_enter = 1'b1;
          end
          sbag_pkg::PH_DIST: begin
            trav_cnt_nxt = '0;
            blk_cnt_nxt  = '0;
            cur_nxt      = '0;
            curm_nxt     = '0;
            do_check     = 1'b1;
          end
          sbag_pkg::PH_TRAV: begin
            cur_nxt  = step_cur;
            curm_nxt = step_curm;
            if (blk_plus < {1'b0, blocks_sel}) begin
              blk_cnt_nxt = blk_plus[IW-1:0];
            end else begin
              trav_cnt_nxt = trav_cnt_r + IW'(1);
              blk_cnt_nxt  = '0;
              cur_nxt      = '0;
              curm_nxt     = '0;
              do_check     = 1'b1;
            end
          end
          default: begin
            do_enter = 1'b1;
          end
        endcase

        // next traversal, or on to the next distance
        if (do_check) begin
          if ((blocks_sel == '0) || (trav_cnt_nxt >= travs_sel)) begin
            do_enter = 1'b1;
            enter_d  = {1'b0, dist_idx_r} + (DI_W+1)'(1);
          end else begin
            phase_nxt = sbag_pkg::PH_TRAV;
          end
        end

        // distance head, or end of the iteration
        if (do_enter) begin
          if (4'(enter_d) < ecount) begin
            dist_idx_nxt = enter_d[DI_W-1:0];
            phase_nxt    = sbag_pkg::PH_DIST;
          end else begin
            dist_idx_nxt  = '0;
            iter_left_nxt = iter_left_r - IW'(1);
            phase_nxt     = sbag_pkg::PH_HEAD;
            if (iter_left_r == IW'(1)) begin
              run_active_nxt = 1'b0;
              res_done       = 1'b1;
            end
          end
        end
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r  <= BW'(1);
      stride_r <= BW'(1);
      dcount_r <= sbag_pkg::DCOUNT_W'(1);
      wmode_r  <= 1'b0;
      for (int i = 0; i < MAX_DISTANCES; i++) begin
        entry_r[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == sbag_pkg::REG_TOTAL)  total_r  <= cfg_data[BW-1:0];
      if (cfg_index == sbag_pkg::REG_STRIDE) stride_r <= cfg_data[BW-1:0];
      if (cfg_index == sbag_pkg::REG_DCOUNT) dcount_r <= cfg_data[sbag_pkg::DCOUNT_W-1:0];
      if (cfg_index == sbag_pkg::REG_WMODE)  wmode_r  <= cfg_data[0];
      for (int i = 0; i < MAX_DISTANCES; i++) begin
        if ((i < sbag_pkg::NUM_ENTRY_REGS) &&
            (cfg_index == sbag_pkg::REG_ENTRY0 + sbag_pkg::CFG_IDX_W'(i))) begin
          entry_r[i] <= cfg_data;
        end
      end
    end
  end

  // Run state; reduced values land when the remainder unit finishes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_active_r <= 1'b0;
      phase_r      <= sbag_pkg::PH_HEAD;
      iter_left_r  <= '0;
      dist_idx_r   <= '0;
      trav_cnt_r   <= '0;
      blk_cnt_r    <= '0;
      cur_r        <= '0;
      curm_r       <= '0;
      stridem_r    <= '0;
    end else begin
      run_active_r <= run_active_nxt;
      phase_r      <= phase_nxt;
      iter_left_r  <= iter_left_nxt;
      dist_idx_r   <= dist_idx_nxt;
      trav_cnt_r   <= trav_cnt_nxt;
      blk_cnt_r    <= blk_cnt_nxt;
      cur_r        <= cur_nxt;
      if (rem_res.done) begin
        curm_r    <= rem_res.rem_a;
        stridem_r <= rem_res.rem_b;
      end else begin
        curm_r    <= curm_nxt;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_blk_r  <= res_blk;
      out_rmw_r  <= res_rmw;
      out_last_r <= res_done;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = OUT_W'(out_blk_r);
  assign out_tuser[0] = out_rmw_r;
  assign out_tlast    = out_last_r;

  // Checks
  a_no_accept_while_reducing: assert property (@(posedge clk) disable iff (!rst_n)
    rem_res.busy |-> !in_tready)
    else $error("request taken while the remainder unit is busy");

  a_reduced_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !rem_res.busy |-> (curm_r < eff_t) && (stridem_r < eff_t))
    else $error("reduced block or stride not below buffer size");

  a_idle_at_head: assert property (@(posedge clk) disable iff (!rst_n)
    !run_active_r |-> (phase_r == sbag_pkg::PH_HEAD))
    else $error("idle run not parked at iteration head");

  a_result_only_when_active: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> run_active_r && (in_tuser[0] == sbag_pkg::CMD_NEXT))
    else $error("access issued outside an active run");

endmodule

`default_nettype wire
